// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files of the flow table.
// No dependencies; every macro samples on the rising edge of clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define FLTB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define FLTB_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/fltb_pkg.sv =====
// Shared constants and the request record passed from front to back of the flow table.
// No dependencies.
package fltb_pkg;

   localparam int BUCKETS_DEF = 256;
   localparam int WAYS_DEF    = 4;
   localparam int KEY_W       = 64;
   localparam int SESS_W      = 16;
   localparam int BKT_MAX_W   = 16;
   localparam int FIFO_DEPTH  = 2;

   localparam logic [31:0] JH_IV = 32'hdeadbef7;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef struct packed {
      logic                 opcode;
      logic                 update_session;
      logic [SESS_W-1:0]    session_id;
      logic [KEY_W-1:0]     key;
      logic [BKT_MAX_W-1:0] bucket;
   } job_type;

endpackage

// ===== src/fltb_front.sv =====
// Front end: accepts a request, forms the key and hashes it to a bucket step by step.
// Depends on fltb_pkg.
module fltb_front #(
   parameter int BUCKETS = fltb_pkg::BUCKETS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   output logic                      full,
   input  logic                      req_opcode,
   input  logic [31:0]               req_src_addr,
   input  logic [31:0]               req_dst_addr,
   input  logic                      req_inbound,
   input  logic                      req_update_session,
   input  logic [fltb_pkg::SESS_W-1:0] req_session_id,
   input  logic                      clear_busy,
   output logic                      job_valid,
   input  logic                      job_ready,
   output fltb_pkg::job_type         job
);

   localparam int  BKT_W   = $clog2(BUCKETS);
   localparam int  R_W     = BKT_W + 1;
   localparam bit  IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / BUCKETS);
   localparam logic [31:0] BKT_C = 32'(BUCKETS);

   typedef enum logic [1:0] {F_IDLE, F_MIX, F_MOD, F_EMIT} state_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
      return (x << r) | (x >> (32 - r));
   endfunction

   state_type   state_ff, state_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [4:0]  step_ff, step_in;
   logic [R_W-1:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [63:0] prod;
   logic [31:0] est;
   fltb_pkg::job_type job_ff, job_in;
   logic [31:0] ks, kd;
   logic        accept;
   logic [BKT_W-1:0] bkt;

   assign full      = (state_ff != F_IDLE) || clear_busy;
   assign accept    = push && !full;
   assign ks        = req_inbound ? req_dst_addr : req_src_addr;
   assign kd        = req_inbound ? req_src_addr : req_dst_addr;
   assign job_valid = (state_ff == F_EMIT);
   assign bkt       = IS_POW2 ? c_ff[BKT_W-1:0] : rem_ff[BKT_W-1:0];
   assign prod      = 64'(c_ff) * 64'(RECIP);
   assign est       = c_ff - quo_ff * BKT_C;

   always_comb begin
      job        = job_ff;
      job.bucket = fltb_pkg::BKT_MAX_W'(bkt);
   end

   always_comb begin
      state_in = state_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      job_in   = job_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               job_in.opcode         = req_opcode;
               job_in.update_session = req_update_session;
               job_in.session_id     = req_session_id;
               job_in.key            = {ks, kd};
               job_in.bucket         = '0;
               a_in     = ks + fltb_pkg::JH_IV;
               b_in     = kd + fltb_pkg::JH_IV;
               c_in     = fltb_pkg::JH_IV;
               step_in  = '0;
               state_in = F_MIX;
            end
         end
         F_MIX: begin
            // One mixing round of the two-word hash per cycle.
            case (step_ff)
               5'd0:    c_in = (c_ff ^ b_ff) - rotl(b_ff, 14);
               5'd1:    a_in = (a_ff ^ c_ff) - rotl(c_ff, 11);
               5'd2:    b_in = (b_ff ^ a_ff) - rotl(a_ff, 25);
               5'd3:    c_in = (c_ff ^ b_ff) - rotl(b_ff, 16);
               5'd4:    a_in = (a_ff ^ c_ff) - rotl(c_ff, 4);
               5'd5:    b_in = (b_ff ^ a_ff) - rotl(a_ff, 14);
               default: c_in = (c_ff ^ b_ff) - rotl(b_ff, 24);
            endcase
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd6) begin
               if (IS_POW2) begin
                  state_in = F_EMIT;
               end else begin
                  state_in = F_MOD;
                  step_in  = 5'd0;
                  rem_in   = '0;
               end
            end
         end
         F_MOD: begin
            // Remainder by the bucket count through a reciprocal. The quotient estimate is
            // at most one short, so a single conditional subtraction finishes it.
            case (step_ff)
               5'd0:    quo_in = prod[63:32];
               5'd1:    rem_in = est[R_W-1:0];
               default: begin
                  rem_in   = (rem_ff >= R_W'(BUCKETS)) ? rem_ff - R_W'(BUCKETS) : rem_ff;
                  state_in = F_EMIT;
               end
            endcase
            step_in = step_ff + 5'd1;
         end
         F_EMIT: begin
            if (job_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      job_ff  <= job_in;
   end

endmodule

// ===== src/fltb_fifo.sv =====
// Short queue of hashed requests between the front and back ends.
// Depends on fltb_pkg.
module fltb_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  fltb_pkg::job_type wr_data,
   output logic              rd_valid,
   input  logic              rd_take,
   output fltb_pkg::job_type rd_data
);

   localparam int D   = fltb_pkg::FIFO_DEPTH;
   localparam int P_W = (D > 1) ? $clog2(D) : 1;
   localparam int C_W = $clog2(D + 1);

   fltb_pkg::job_type ent_ff [D];
   logic [P_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [C_W-1:0] cnt_ff, cnt_in;
   logic           do_wr, do_rd;

   assign wr_ready = (cnt_ff != C_W'(D));
   assign rd_valid = (cnt_ff != '0);
   assign rd_data  = ent_ff[rp_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_take && rd_valid;

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (do_wr) begin
         wp_in = (wp_ff == P_W'(D - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (do_rd) begin
         rp_in = (rp_ff == P_W'(D - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_wr) begin
         ent_ff[wp_ff] <= wr_data;
      end
   end

endmodule

// ===== src/fltb_back.sv =====
// Back end: reads a bucket, matches or inserts, updates recency order and holds the result.
// Depends on fltb_pkg.
module fltb_back #(
   parameter int BUCKETS = fltb_pkg::BUCKETS_DEF,
   parameter int WAYS    = fltb_pkg::WAYS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        job_valid,
   output logic                        job_take,
   input  fltb_pkg::job_type           job,
   output logic                        clear_busy,
   output logic                        empty,
   input  logic                        pop,
   output logic                        rsp_found,
   output logic [fltb_pkg::SESS_W-1:0] rsp_found_session
);

   localparam int SESS_W = fltb_pkg::SESS_W;
   localparam int KEY_W  = fltb_pkg::KEY_W;
   localparam int BKT_W  = $clog2(BUCKETS);
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int FILL_W = $clog2(WAYS + 1);
   localparam int ENT_W  = KEY_W + SESS_W;
   localparam int ORD_W  = WAYS * WAY_W;
   localparam int META_W = FILL_W + ORD_W;

   typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_EXEC} state_type;
   typedef logic [WAYS-1:0][WAY_W-1:0] order_type;
   typedef logic [WAYS-1:0][ENT_W-1:0] row_type;

   // Per bucket: fill count and recency order. Per bucket row: key and session of each way.
   logic [META_W-1:0] meta_mem [BUCKETS];
   row_type           row_mem  [BUCKETS];

   state_type         state_ff, state_in;
   logic [BKT_W-1:0]  clr_ff, clr_in;
   logic              rv_ff, rv_in;
   logic              found_ff, found_in;
   logic [SESS_W-1:0] sess_ff, sess_in;
   fltb_pkg::job_type job_ff;
   logic [META_W-1:0] meta_q_ff;
   row_type           row_q_ff;

   logic              rsp_take, start;
   logic [BKT_W-1:0]  rd_addr, bk;
   logic [FILL_W-1:0] fill, new_fill;
   order_type         order, new_order, ident;
   row_type           new_row;
   logic [WAYS-1:0]   way_hit, pos_hit;
   logic              hit, is_ins, bkt_full;
   logic [WAY_W-1:0]  sel, pos, w;

   assign rsp_take          = pop && rv_ff;
   assign empty             = !rv_ff;
   assign rsp_found         = found_ff;
   assign rsp_found_session = sess_ff;
   assign clear_busy        = (state_ff == B_CLEAR);
   assign start    = (state_ff == B_IDLE) && job_valid && (!rv_ff || rsp_take);
   assign job_take = start;
   assign rd_addr  = job.bucket[BKT_W-1:0];
   assign bk       = job_ff.bucket[BKT_W-1:0];
   assign fill     = meta_q_ff[META_W-1 -: FILL_W];
   assign order    = order_type'(meta_q_ff[ORD_W-1:0]);
   assign is_ins   = (job_ff.opcode == fltb_pkg::OP_INSERT);
   assign bkt_full = int'(fill) >= WAYS;

   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         ident[i] = WAY_W'(i);
      end
   end

   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         way_hit[i] = (row_q_ff[i][ENT_W-1:SESS_W] == job_ff.key);
      end
      for (int p = 0; p < WAYS; p++) begin
         pos_hit[p] = (int'(fill) > p) && way_hit[order[p]];
      end
      // The most recent matching position wins.
      hit = 1'b0;
      sel = '0;
      for (int p = WAYS - 1; p >= 0; p--) begin
         if (pos_hit[p]) begin
            hit = 1'b1;
            sel = WAY_W'(p);
         end
      end
      if (is_ins) begin
         pos = bkt_full ? WAY_W'(WAYS - 1) : WAY_W'(fill);
      end else begin
         pos = sel;
      end
      w = order[pos];

      new_order = order;
      if (is_ins || hit) begin
         new_order[0] = w;
         for (int p = 1; p < WAYS; p++) begin
            new_order[p] = (p <= int'(pos)) ? order[p-1] : order[p];
         end
      end

      new_row = row_q_ff;
      if (is_ins) begin
         new_row[w] = {job_ff.key, job_ff.session_id};
      end else if (hit && job_ff.update_session) begin
         new_row[w][SESS_W-1:0] = job_ff.session_id;
      end
      new_fill = (is_ins && !bkt_full) ? fill + 1'b1 : fill;
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      rv_in    = rv_ff;
      found_in = found_ff;
      sess_in  = sess_ff;
      if (rsp_take) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         B_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == BKT_W'(BUCKETS - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (start) begin
               state_in = B_EXEC;
            end
         end
         B_EXEC: begin
            rv_in    = 1'b1;
            found_in = !is_ins && hit;
            sess_in  = (!is_ins && hit) ? new_row[w][SESS_W-1:0] : '0;
            state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_CLEAR;
         clr_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         rv_ff    <= rv_in;
      end
      found_ff <= found_in;
      sess_ff  <= sess_in;
      if (start) begin
         job_ff <= job;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_CLEAR) begin
         meta_mem[clr_ff] <= {FILL_W'(0), ORD_W'(ident)};
      end else if (state_ff == B_EXEC) begin
         meta_mem[bk] <= {new_fill, ORD_W'(new_order)};
         row_mem[bk]  <= new_row;
      end
      if (start) begin
         meta_q_ff <= meta_mem[rd_addr];
         row_q_ff  <= row_mem[rd_addr];
      end
   end

endmodule

// ===== src/flow_table_lru_buckets.sv =====
// Top level of the hashed flow table with per-bucket recency order.
// Depends on fltb_pkg, fltb_front, fltb_fifo and fltb_back.
//
//   Side      Handshake    Carries
//   request   push / full  req_opcode, addresses, direction, update flag, session
//   result    pop / empty  rsp_found, rsp_found_session
//
// The front end hashes one request at a time, with a reciprocal remainder step when
// BUCKETS is not a power of two, and holds full high until the request enters the queue.
// The back end handles one request at a time: one bucket read, then compare and
// write-back on the single memory port. After reset a clearing pass initialises the
// bucket table; full is high until it ends. A result held unpopped stalls the back end,
// and through the queue of two requests, the front end.
module flow_table_lru_buckets #(
   parameter int BUCKETS = fltb_pkg::BUCKETS_DEF,
   parameter int WAYS    = fltb_pkg::WAYS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic                        req_opcode,
   input  logic [31:0]                 req_src_addr,
   input  logic [31:0]                 req_dst_addr,
   input  logic                        req_inbound,
   input  logic                        req_update_session,
   input  logic [fltb_pkg::SESS_W-1:0] req_session_id,
   output logic                        empty,
   input  logic                        pop,
   output logic                        rsp_found,
   output logic [fltb_pkg::SESS_W-1:0] rsp_found_session
);

   fltb_pkg::job_type fr_job, q_job;
   logic fr_valid, q_ready, q_valid, q_take, clear_busy;

   fltb_front #(.BUCKETS(BUCKETS)) u_front (
      .clock              (clock),
      .reset              (reset),
      .push               (push),
      .full               (full),
      .req_opcode         (req_opcode),
      .req_src_addr       (req_src_addr),
      .req_dst_addr       (req_dst_addr),
      .req_inbound        (req_inbound),
      .req_update_session (req_update_session),
      .req_session_id     (req_session_id),
      .clear_busy         (clear_busy),
      .job_valid          (fr_valid),
      .job_ready          (q_ready),
      .job                (fr_job)
   );

   fltb_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fr_valid),
      .wr_ready (q_ready),
      .wr_data  (fr_job),
      .rd_valid (q_valid),
      .rd_take  (q_take),
      .rd_data  (q_job)
   );

   fltb_back #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_back (
      .clock             (clock),
      .reset             (reset),
      .job_valid         (q_valid),
      .job_take          (q_take),
      .job               (q_job),
      .clear_busy        (clear_busy),
      .empty             (empty),
      .pop               (pop),
      .rsp_found         (rsp_found),
      .rsp_found_session (rsp_found_session)
   );

endmodule

// ===== src/fltb_checker.sv =====
// Port-level checks on the flow table, bound to its top level.
// Depends on assert_macros.svh and fltb_pkg.
`include "assert_macros.svh"

module fltb_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        full,
   input logic                        empty,
   input logic                        pop,
   input logic                        rsp_found,
   input logic [fltb_pkg::SESS_W-1:0] rsp_found_session
);

   // A waiting result stays put until it is popped.
   `FLTB_ASSERT(a_rsp_hold, !empty && !pop |=> !empty && $stable(rsp_found) && $stable(rsp_found_session), "result changed while waiting")

   // A miss or an insert reports a zero session.
   `FLTB_ASSERT(a_miss_zero, !empty && !rsp_found |-> rsp_found_session == 16'd0, "non-zero session without a hit")

   // Reset empties the result side and holds requests off for the clearing pass.
   `FLTB_ASSERT_ALWAYS(a_reset_state, reset |=> full && empty, "wrong state after reset")

endmodule

bind flow_table_lru_buckets fltb_checker u_fltb_checker (.*);

// ===== verif/flow_table_lru_buckets_tb.sv =====
// Self-checking testbench for the hashed flow table with per-bucket recency order.
// Depends on fltb_pkg and flow_table_lru_buckets; carries its own model of the table.
module flow_table_lru_buckets_tb;

   localparam int NBKT = 256;
   localparam int NWAY = 4;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic                        found;
      logic [fltb_pkg::SESS_W-1:0] session;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty;
   logic req_opcode = fltb_pkg::OP_LOOKUP;
   logic [31:0] req_src_addr = '0;
   logic [31:0] req_dst_addr = '0;
   logic req_inbound = 1'b0;
   logic req_update_session = 1'b0;
   logic [fltb_pkg::SESS_W-1:0] req_session_id = '0;
   logic rsp_found;
   logic [fltb_pkg::SESS_W-1:0] rsp_found_session;

   // Model of the table.
   logic [fltb_pkg::KEY_W-1:0]  mdl_keys[NBKT*NWAY];
   logic [fltb_pkg::SESS_W-1:0] mdl_sess[NBKT*NWAY];
   int                          mdl_fill[NBKT];
   int                          mdl_order[NBKT][NWAY];

   answer_type answers_due[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int errors = 0;
   int n_sent = 0;
   int n_hits = 0;
   int idle_count = 0;
   bit timed_out = 1'b0;
   // Recently used address pairs, so that lookups hit.
   logic [31:0] pool_a[$];
   logic [31:0] pool_b[$];

   flow_table_lru_buckets i_dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_opcode(req_opcode), .req_src_addr(req_src_addr),
      .req_dst_addr(req_dst_addr), .req_inbound(req_inbound),
      .req_update_session(req_update_session), .req_session_id(req_session_id),
      .empty(empty), .pop(pop), .rsp_found(rsp_found),
      .rsp_found_session(rsp_found_session)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] rol(logic [31:0] x, int r);
      return (x << r) | (x >> (32 - r));
   endfunction

   function automatic int bucket_of(logic [31:0] a, logic [31:0] b);
      logic [31:0] c;
      c = fltb_pkg::JH_IV;
      a = a + fltb_pkg::JH_IV;
      b = b + fltb_pkg::JH_IV;
      c = c ^ b; c = c - rol(b, 14);
      a = a ^ c; a = a - rol(c, 11);
      b = b ^ a; b = b - rol(a, 25);
      c = c ^ b; c = c - rol(b, 16);
      a = a ^ c; a = a - rol(c, 4);
      b = b ^ a; b = b - rol(a, 14);
      c = c ^ b; c = c - rol(b, 24);
      return int'(c % NBKT);
   endfunction

   function automatic void move_to_front(int bk, int pos);
      int w;
      w = mdl_order[bk][pos];
      for (int p = pos; p > 0; p--) mdl_order[bk][p] = mdl_order[bk][p-1];
      mdl_order[bk][0] = w;
   endfunction

   function automatic answer_type predict_flow(logic op, logic [31:0] src, logic [31:0] dst,
                                               logic inb, logic upd,
                                               logic [fltb_pkg::SESS_W-1:0] sess);
      answer_type ans;
      logic [31:0] ks, kd;
      logic [fltb_pkg::KEY_W-1:0] key;
      int bk, idx, pos;
      ans.found = 1'b0;
      ans.session = '0;
      ks = inb ? dst : src;
      kd = inb ? src : dst;
      key = {ks, kd};
      bk = bucket_of(ks, kd);
      if (op == fltb_pkg::OP_LOOKUP) begin
         for (pos = 0; pos < mdl_fill[bk]; pos++) begin
            idx = bk * NWAY + mdl_order[bk][pos];
            if (mdl_keys[idx] == key) begin
               if (upd) mdl_sess[idx] = sess;
               ans.found = 1'b1;
               ans.session = mdl_sess[idx];
               move_to_front(bk, pos);
               break;
            end
         end
      end else begin
         if (mdl_fill[bk] >= NWAY) begin
            pos = NWAY - 1;
         end else begin
            pos = mdl_fill[bk];
            mdl_fill[bk]++;
         end
         idx = bk * NWAY + mdl_order[bk][pos];
         mdl_keys[idx] = key;
         mdl_sess[idx] = sess;
         move_to_front(bk, pos);
      end
      return ans;
   endfunction

   // Sends one request and waits for it to be taken; push stays high until the next call.
   task automatic send_request(logic op, logic [31:0] src, logic [31:0] dst,
                               logic inb, logic upd, logic [fltb_pkg::SESS_W-1:0] sess);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_opcode <= op;
      req_src_addr <= src;
      req_dst_addr <= dst;
      req_inbound <= inb;
      req_update_session <= upd;
      req_session_id <= sess;
      do @(posedge clock); while (full);
      answers_due.push_back(predict_flow(op, src, dst, inb, upd, sess));
      n_sent++;
   endtask

   // Result side: random pop and comparison against the oldest prediction.
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) begin
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected result found=%0b session=%0h",
                        $time, rsp_found, rsp_found_session);
               errors++;
            end else begin
               if (rsp_found !== answers_due[0].found ||
                   rsp_found_session !== answers_due[0].session) begin
                  $display("%0t: expected found=%0b session=%0h, actual found=%0b session=%0h",
                           $time, answers_due[0].found, answers_due[0].session,
                           rsp_found, rsp_found_session);
                  errors++;
               end
               if (answers_due[0].found) n_hits++;
               void'(answers_due.pop_front());
            end
         end
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles with no accepted request or result.
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count > WATCHDOG_LIMIT) begin
         timed_out = 1'b1;
         $display("flow_table_lru_buckets_tb NOT OK");
         $finish;
      end
   end

   task automatic test_directed;
      logic [31:0] a, b;
      a = 32'h0a000001;
      b = 32'hc0a80002;
      send_request(fltb_pkg::OP_LOOKUP, a, b, 1'b0, 1'b0, 16'h1111);   // miss on empty table
      send_request(fltb_pkg::OP_INSERT, a, b, 1'b0, 1'b1, 16'hffff);   // update flag ignored
      send_request(fltb_pkg::OP_LOOKUP, a, b, 1'b0, 1'b0, 16'h0);
      send_request(fltb_pkg::OP_LOOKUP, b, a, 1'b1, 1'b0, 16'h0);      // inbound swap hits
      send_request(fltb_pkg::OP_LOOKUP, b, a, 1'b0, 1'b0, 16'h0);
      send_request(fltb_pkg::OP_LOOKUP, a, b, 1'b0, 1'b1, 16'h0000);   // updating hit
      send_request(fltb_pkg::OP_INSERT, a, b, 1'b0, 1'b0, 16'h4242);   // duplicate key
      send_request(fltb_pkg::OP_LOOKUP, a, b, 1'b0, 1'b0, 16'h0);
      send_request(fltb_pkg::OP_INSERT, '0, '0, 1'b0, 1'b0, 16'h0);
      send_request(fltb_pkg::OP_INSERT, '1, '1, 1'b1, 1'b0, 16'hffff);
      send_request(fltb_pkg::OP_LOOKUP, '0, '0, 1'b0, 1'b0, 16'h0);
      send_request(fltb_pkg::OP_LOOKUP, '1, '1, 1'b0, 1'b1, 16'h8001);
      // Six inserts of keys sharing a source address, then lookups of them in reverse order.
      for (int i = 0; i < 6; i++)
         send_request(fltb_pkg::OP_INSERT, 32'h55, 32'(i), 1'b0, 1'b0, 16'(i + 7));
      for (int i = 5; i >= 0; i--)
         send_request(fltb_pkg::OP_LOOKUP, 32'h55, 32'(i), 1'b0, 1'b0, 16'h0);
   endtask

   task automatic test_random(int count);
      logic [31:0] a, b;
      int k;
      for (int i = 0; i < count; i++) begin
         if (pool_a.size() > 0 && $urandom_range(99) < 70) begin
            k = $urandom_range(pool_a.size() - 1);
            a = pool_a[k];
            b = pool_b[k];
         end else begin
            a = $urandom();
            b = ($urandom_range(3) == 0) ? 32'($urandom_range(7)) : $urandom();
            pool_a.push_back(a);
            pool_b.push_back(b);
            if (pool_a.size() > 60) begin
               void'(pool_a.pop_front());
               void'(pool_b.pop_front());
            end
         end
         if ($urandom_range(1) != 0) send_request($urandom_range(99) < 35, b, a, 1'b1,
                                                  1'($urandom_range(1)),
                                                  16'($urandom_range(65535)));
         else send_request($urandom_range(99) < 35, a, b, 1'b0,
                           1'($urandom_range(1)), 16'($urandom_range(65535)));
      end
   endtask

   task automatic drain;
      push <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      for (int b = 0; b < NBKT; b++) begin
         mdl_fill[b] = 0;
         for (int w = 0; w < NWAY; w++) mdl_order[b][w] = w;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      send_idle_pct = 21; recv_idle_pct = 46;
      test_random(300);
      send_idle_pct = 46; recv_idle_pct = 21;
      test_random(300);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(300);
      drain();
      $display("Sent %0d requests of lookups and inserts, %0d lookup hits seen,", n_sent, n_hits);
      $display("covering duplicates, inbound swaps, session updates and evictions.");
      if (errors == 0 && !timed_out) begin
         $display("flow_table_lru_buckets_tb OK");
      end else begin
         $display("flow_table_lru_buckets_tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/fltb_pkg.sv
src/fltb_front.sv
src/fltb_fifo.sv
src/fltb_back.sv
src/flow_table_lru_buckets.sv
src/fltb_checker.sv
verif/flow_table_lru_buckets_tb.sv
